### src/tcsum_pkg.sv
`timescale 1ns / 1ps
// Package for the TCP segment checksum core: word types, header offsets,
// status codes and the ones-complement add. No dependencies.
package tcsum_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
    } t_in_word;

    typedef struct packed {
        logic [15:0] checksum;
        logic [15:0] segment_length;
        logic [1:0]  status;
    } t_out_word;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EARLY_END = 2'd1;
    localparam logic [1:0] ST_SHORT_LEN = 2'd2;

    // IPv4 header byte positions
    localparam logic [15:0] POS_LEN_HI  = 16'd2;
    localparam logic [15:0] POS_LEN_LO  = 16'd3;
    localparam logic [15:0] POS_PROTO   = 16'd9;
    localparam logic [15:0] POS_SRC     = 16'd12;
    localparam logic [15:0] HDR_LEN     = 16'd20;
    // checksum field offset within the TCP segment
    localparam logic [15:0] CKSUM_OFS   = 16'd16;
    localparam logic [15:0] POS_MAX     = 16'hFFFF;

    function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        logic [16:0] f;
        s = {1'b0, a} + {1'b0, b};
        f = {1'b0, s[15:0]} + {16'd0, s[16]};
        return f[15:0];
    endfunction

endpackage

### src/tcsum_stream_if.sv
`timescale 1ns / 1ps
// Valid/ready stream interface carrying one payload word per handshake.
// Payload type is a parameter; word types come from tcsum_pkg.
interface tcsum_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

### src/tcp_segment_checksum_core.sv
`timescale 1ns / 1ps
// TCP checksum over an IPv4 packet including the IPv4 pseudo header.
// Depends on tcsum_pkg and tcsum_stream_if.
//
// Usage:
//   i_in  : one packet byte per word (data_byte, last), 20-byte IPv4 header
//           first, in wire order. last marks the final byte of the packet.
//   o_out : one word per packet, issued for the input word with last set:
//           checksum (complemented ones-complement sum), segment_length
//           (total length minus 20, else 0) and status (ok, early end, short length).
//   Throughput: one byte per cycle while i_in.ready is high. Each byte
//   updates the running sum with at most a single 16-bit end-around add;
//   the result is held in one output register.
//   Latency: the result word is valid the cycle after the last byte is
//   accepted.
//   Stall: while the output register holds an untaken word, a new byte is
//   still accepted in the cycle the receiver takes it; otherwise i_in.ready
//   drops until the word is taken.
//   Reset (i_rst_n low, synchronous): packet state clears and the output
//   register empties. State also clears after every last byte.
module tcp_segment_checksum_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    tcsum_stream_if.sink          i_in,
    tcsum_stream_if.source        o_out
);
    import tcsum_pkg::*;

    logic [15:0] r_byte_pos, n_byte_pos;
    logic [15:0] r_total_len, n_total_len;
    logic [15:0] r_sum, n_sum;
    logic [7:0]  r_held, n_held;
    logic        r_out_valid;
    t_out_word   r_out, n_out;

    logic        w_accept;
    t_in_word    w_in;
    logic [15:0] w_addend;
    logic        w_add_en;
    logic [15:0] w_seg_pos;
    logic [7:0]  w_seg_byte;
    logic        w_len_known;
    logic [15:0] w_seg_len;
    logic [16:0] w_end;
    logic [15:0] w_final_sum;

    assign w_in     = i_in.payload;
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_accept = i_in.valid && i_in.ready;

    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

    assign w_seg_pos  = r_byte_pos - HDR_LEN;
    assign w_seg_byte = (w_seg_pos == CKSUM_OFS || w_seg_pos == CKSUM_OFS + 16'd1)
                        ? 8'd0 : w_in.data_byte;

    // per-byte state update: at most one addend selected, at most one end-around add
    always_comb begin
        n_total_len = r_total_len;
        n_held      = r_held;
        w_addend    = 16'd0;
        w_add_en    = 1'b0;
        if (r_byte_pos == POS_LEN_HI) begin
            n_total_len = {w_in.data_byte, r_total_len[7:0]};
        end else if (r_byte_pos == POS_LEN_LO) begin
            n_total_len = {r_total_len[15:8], w_in.data_byte};
            if (n_total_len >= HDR_LEN) begin
                w_addend = n_total_len - HDR_LEN;
                w_add_en = 1'b1;
            end
        end else if (r_byte_pos == POS_PROTO) begin
            w_addend = {8'd0, w_in.data_byte};
            w_add_en = 1'b1;
        end else if (r_byte_pos >= POS_SRC && r_byte_pos < HDR_LEN) begin
            if (!r_byte_pos[0]) begin
                n_held = w_in.data_byte;
            end else begin
                w_addend = {r_held, w_in.data_byte};
                w_add_en = 1'b1;
            end
        end else if (r_byte_pos >= HDR_LEN && r_byte_pos < r_total_len) begin
            // header length is even, so segment parity is position parity
            if (!r_byte_pos[0]) begin
                n_held = w_seg_byte;
            end else begin
                w_addend = {r_held, w_seg_byte};
                w_add_en = 1'b1;
            end
        end
        n_sum      = w_add_en ? oc_add(r_sum, w_addend) : r_sum;
        n_byte_pos = (r_byte_pos != POS_MAX) ? r_byte_pos + 16'd1 : r_byte_pos;
    end

    // end-of-packet result
    always_comb begin
        w_len_known = (r_byte_pos >= POS_LEN_LO);
        w_end       = {1'b0, r_byte_pos} + 17'd1;
        w_seg_len   = (w_len_known && n_total_len >= HDR_LEN) ? n_total_len - HDR_LEN : 16'd0;
        w_final_sum = w_seg_len[0] ? oc_add(n_sum, {n_held, 8'd0}) : n_sum;
        n_out.segment_length = w_seg_len;
        if (w_len_known && n_total_len < HDR_LEN) begin
            n_out.checksum = 16'd0;
            n_out.status   = ST_SHORT_LEN;
        end else if (!w_len_known || w_end < {1'b0, HDR_LEN} || w_end < {1'b0, n_total_len}) begin
            n_out.checksum = 16'd0;
            n_out.status   = ST_EARLY_END;
        end else begin
            n_out.checksum = ~w_final_sum;
            n_out.status   = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_pos  <= '0;
            r_total_len <= '0;
            r_sum       <= '0;
            r_held      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                if (w_in.last) begin
                    r_byte_pos  <= '0;
                    r_total_len <= '0;
                    r_sum       <= '0;
                    r_held      <= '0;
                end else begin
                    r_byte_pos  <= n_byte_pos;
                    r_total_len <= n_total_len;
                    r_sum       <= n_sum;
                    r_held      <= n_held;
                end
            end
            if (w_accept && w_in.last) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_in.last) begin
            r_out <= n_out;
        end
    end

endmodule
